// ===== rtl/core/bba_pkg.sv =====
// Shared constants, opcodes and sequencer states for the bitmap block allocator.
package bba_pkg;

  localparam int MAX_BLOCKS  = 32768;
  localparam int BLOCK_BYTES = 4096;
  localparam int BLOCK_SHIFT = 12;
  localparam int WORD_BITS   = 32;
  localparam int MAP_WORDS   = MAX_BLOCKS / WORD_BITS;
  localparam int WORD_AW     = $clog2(MAP_WORDS);
  localparam int BIT_AW      = $clog2(WORD_BITS);
  localparam int BLK_W       = $clog2(MAX_BLOCKS) + 2;
  localparam int ADDR_W      = 48;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [WORD_AW-1:0]   waddr_t;

  typedef enum logic [2:0] {
    OP_ALLOC      = 3'd0,
    OP_MARK_USED  = 3'd1,
    OP_MARK_FREE  = 3'd2,
    OP_READ_BIT   = 3'd3,
    OP_WRITE_BIT  = 3'd4
  } op_t;

  typedef enum logic [0:0] {
    CFG_BASE  = 1'b0,
    CFG_TOTAL = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_OFF,
    S_RANGE,
    S_CLIP,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_MK_RD,
    S_MK_WR,
    S_BIT_RD,
    S_BIT_WR,
    S_DONE
  } state_t;

endpackage

// ===== rtl/core/bitmap_block_allocator.sv =====
// Top level: configuration, search hint and the sequencer around the bitmap memory.
//
// Usage:
//   Input channel: an item is taken when start is high and busy is low.
//   in_op selects allocate, mark used, mark free, read bit or write bit.
//   Result channel: out_valid pulses for one cycle with out_ok,
//   out_alloc_address and out_bit_read; the receiver cannot stall it.
//   busy stays high from acceptance through the result cycle.
//   Config: cfg_we writes cfg_wdata into register cfg_index (0 base
//   address, 1 total blocks); write only while busy is low.
// Sequence:
//   Read/write bit: range check and map read, then bit update. Mark ops:
//   offset, range, clip, then a read and a write per map word touched.
//   Allocate: a read and check per uniform word scanned, else a check per
//   bit, then run marking; single read port and per-bit check set worst case.
// Reset:
//   rst_n low clears the hint and base address and sets total blocks to
//   32768; afterwards busy holds high while every map word is written free.
module bitmap_block_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_op,
  input  logic [47:0] in_address,
  input  logic [27:0] in_byte_size,
  input  logic [15:0] in_block_count,
  input  logic [14:0] in_block_index,
  input  logic        in_bit_value,
  output logic        out_valid,
  output logic        out_ok,
  output logic [47:0] out_alloc_address,
  output logic        out_bit_read,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [47:0] cfg_wdata
);
  import bba_pkg::*;

  state_t state_r, state_nxt;
  logic [47:0] base_r;
  logic [15:0] total_r;
  logic [15:0] hint_r, hint_nxt;
  logic [WORD_AW-1:0] clr_r, clr_nxt;

  logic [2:0]  op_r, op_nxt;
  logic [47:0] addr_r, addr_nxt;
  logic [27:0] bytes_r, bytes_nxt;
  logic [15:0] want_r, want_nxt;
  logic [14:0] idx_r, idx_nxt;
  logic        bitv_r, bitv_nxt;
  logic        setv_r, setv_nxt;

  logic [47:0] off_r, off_nxt;
  logic [36:0] start_r, start_nxt;
  logic [16:0] cnt_r, cnt_nxt;

  logic [BLK_W-1:0] b_r, b_nxt;
  logic [BLK_W-1:0] run_start_r, run_start_nxt;
  logic [BLK_W-1:0] run_len_r, run_len_nxt;
  logic [BLK_W-1:0] mk_end_r, mk_end_nxt;

  logic        ok_r, ok_nxt;
  logic [47:0] res_r, res_nxt;
  logic        rd_r, rd_nxt;

  logic [15:0] lim;
  logic        ram_we, ram_re;
  waddr_t      ram_waddr, ram_raddr;
  word_t       ram_wdata, ram_rdata;

  logic [37:0] end_full;
  logic [37:0] end_clip;
  logic [BLK_W-1:0] word_end;
  logic [5:0]  hi;
  logic [32:0] mask33;
  word_t       mask;
  logic [BLK_W-1:0] run_len_inc;

  assign lim = (total_r > 16'(MAX_BLOCKS)) ? 16'(MAX_BLOCKS) : total_r;

  bba_map_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      base_r  <= '0;
      total_r <= 16'(MAX_BLOCKS);
      hint_r  <= '0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      hint_r  <= hint_nxt;
      clr_r   <= clr_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_BASE:  base_r  <= cfg_wdata;
          CFG_TOTAL: total_r <= cfg_wdata[15:0];
          default:   base_r  <= base_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    addr_r      <= addr_nxt;
    bytes_r     <= bytes_nxt;
    want_r      <= want_nxt;
    idx_r       <= idx_nxt;
    bitv_r      <= bitv_nxt;
    setv_r      <= setv_nxt;
    off_r       <= off_nxt;
    start_r     <= start_nxt;
    cnt_r       <= cnt_nxt;
    b_r         <= b_nxt;
    run_start_r <= run_start_nxt;
    run_len_r   <= run_len_nxt;
    mk_end_r    <= mk_end_nxt;
    ok_r        <= ok_nxt;
    res_r       <= res_nxt;
    rd_r        <= rd_nxt;
  end

  always_comb begin
    end_full    = {1'b0, start_r} + {21'd0, cnt_r};
    end_clip    = (end_full > {22'd0, lim}) ? {22'd0, lim} : end_full;
    word_end    = {b_r[BLK_W-1:BIT_AW] + 12'd1, 5'd0};
    hi          = (mk_end_r < word_end) ? {1'b0, mk_end_r[BIT_AW-1:0]} : 6'(WORD_BITS);
    mask33      = ((33'd1 << hi) - 33'd1) & ~((33'd1 << b_r[BIT_AW-1:0]) - 33'd1);
    mask        = mask33[WORD_BITS-1:0];
    run_len_inc = run_len_r + 17'd1;
  end

  always_comb begin
    state_nxt     = state_r;
    hint_nxt      = hint_r;
    clr_nxt       = clr_r;
    op_nxt        = op_r;
    addr_nxt      = addr_r;
    bytes_nxt     = bytes_r;
    want_nxt      = want_r;
    idx_nxt       = idx_r;
    bitv_nxt      = bitv_r;
    setv_nxt      = setv_r;
    off_nxt       = off_r;
    start_nxt     = start_r;
    cnt_nxt       = cnt_r;
    b_nxt         = b_r;
    run_start_nxt = run_start_r;
    run_len_nxt   = run_len_r;
    mk_end_nxt    = mk_end_r;
    ok_nxt        = ok_r;
    res_nxt       = res_r;
    rd_nxt        = rd_r;
    ram_we        = 1'b0;
    ram_waddr     = b_r[WORD_AW+BIT_AW-1:BIT_AW];
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = b_r[WORD_AW+BIT_AW-1:BIT_AW];

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + 10'd1;
        if (clr_r == WORD_AW'(MAP_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          op_nxt    = in_op;
          addr_nxt  = in_address;
          bytes_nxt = in_byte_size;
          want_nxt  = in_block_count;
          idx_nxt   = in_block_index;
          bitv_nxt  = in_bit_value;
          ok_nxt    = 1'b0;
          res_nxt   = '0;
          rd_nxt    = 1'b0;
          case (in_op)
            OP_ALLOC: begin
              setv_nxt      = 1'b1;
              b_nxt         = {1'b0, hint_r};
              run_start_nxt = {1'b0, hint_r};
              run_len_nxt   = '0;
              state_nxt     = (in_block_count == 16'd0) ? S_DONE : S_SRCH_RD;
            end
            OP_MARK_USED, OP_MARK_FREE: begin
              setv_nxt  = (in_op == OP_MARK_USED);
              state_nxt = S_OFF;
            end
            OP_READ_BIT, OP_WRITE_BIT: begin
              b_nxt     = {2'b00, in_block_index};
              state_nxt = S_BIT_RD;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_OFF: begin
        off_nxt = addr_r - base_r;
        if (addr_r < base_r) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_RANGE;
        end
      end
      S_RANGE: begin
        if (setv_r) begin
          start_nxt = {1'b0, off_r[47:BLOCK_SHIFT]};
          cnt_nxt   = 17'(({1'b0, bytes_r} + 29'(BLOCK_BYTES - 1)) >> BLOCK_SHIFT);
        end else begin
          start_nxt = 37'(({1'b0, off_r} + 49'(BLOCK_BYTES - 1)) >> BLOCK_SHIFT);
          cnt_nxt   = {1'b0, bytes_r[27:BLOCK_SHIFT]};
        end
        state_nxt = S_CLIP;
      end
      S_CLIP: begin
        ok_nxt = 1'b1;
        if (!setv_r && (start_r < {21'd0, hint_r})) begin
          hint_nxt = start_r[15:0];
        end
        if ({1'b0, start_r} < end_clip) begin
          b_nxt      = start_r[BLK_W-1:0];
          mk_end_nxt = end_clip[BLK_W-1:0];
          state_nxt  = S_MK_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SRCH_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_SRCH_CHK;
      end
      S_SRCH_CHK: begin
        if (b_r >= {1'b0, lim}) begin
          state_nxt = S_DONE;
        end else if ((b_r[BIT_AW-1:0] == '0) && (ram_rdata == '0)
                     && ((b_r + 17'(WORD_BITS)) <= {1'b0, lim})
                     && ((run_len_r + 17'(WORD_BITS)) < {1'b0, want_r})) begin
          run_len_nxt = run_len_r + 17'(WORD_BITS);
          b_nxt       = b_r + 17'(WORD_BITS);
          state_nxt   = S_SRCH_RD;
        end else if ((b_r[BIT_AW-1:0] == '0) && (ram_rdata == '1)
                     && ((b_r + 17'(WORD_BITS)) <= {1'b0, lim})) begin
          run_len_nxt   = '0;
          run_start_nxt = b_r + 17'(WORD_BITS);
          b_nxt         = b_r + 17'(WORD_BITS);
          state_nxt     = S_SRCH_RD;
        end else if (ram_rdata[b_r[BIT_AW-1:0]]) begin
          run_len_nxt   = '0;
          run_start_nxt = b_r + 17'd1;
          b_nxt         = b_r + 17'd1;
          if (b_r[BIT_AW-1:0] == '1) begin
            state_nxt = S_SRCH_RD;
          end
        end else if (run_len_inc >= {1'b0, want_r}) begin
          if (want_r == 16'd1) begin
            hint_nxt = 16'(run_start_r + 17'd1);
          end
          ok_nxt     = 1'b1;
          res_nxt    = base_r + (ADDR_W'(run_start_r) << BLOCK_SHIFT);
          b_nxt      = run_start_r;
          mk_end_nxt = run_start_r + {1'b0, want_r};
          state_nxt  = S_MK_RD;
        end else begin
          run_len_nxt = run_len_inc;
          b_nxt       = b_r + 17'd1;
          if (b_r[BIT_AW-1:0] == '1) begin
            state_nxt = S_SRCH_RD;
          end
        end
      end
      S_MK_RD: begin
        if (b_r >= mk_end_r) begin
          state_nxt = S_DONE;
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_MK_WR;
        end
      end
      S_MK_WR: begin
        ram_we    = 1'b1;
        ram_wdata = setv_r ? (ram_rdata | mask) : (ram_rdata & ~mask);
        b_nxt     = word_end;
        state_nxt = S_MK_RD;
      end
      S_BIT_RD: begin
        if ({2'b00, idx_r} < {1'b0, lim}) begin
          ram_re    = 1'b1;
          state_nxt = S_BIT_WR;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_BIT_WR: begin
        ok_nxt    = 1'b1;
        state_nxt = S_DONE;
        if (op_r == OP_READ_BIT) begin
          rd_nxt = ram_rdata[idx_r[BIT_AW-1:0]];
        end else begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          ram_wdata[idx_r[BIT_AW-1:0]] = bitv_r;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = (state_r == S_DONE);
  assign out_ok            = ok_r;
  assign out_alloc_address = res_r;
  assign out_bit_read      = rd_r;

endmodule

// ===== rtl/core/bba_map_ram.sv =====
// Single-port-write, single-port-read bitmap memory with registered read data.
module bba_map_ram (
  input  logic           clk,
  input  logic           we,
  input  bba_pkg::waddr_t waddr,
  input  bba_pkg::word_t  wdata,
  input  logic           re,
  input  bba_pkg::waddr_t raddr,
  output bba_pkg::word_t  rdata
);
  import bba_pkg::*;

  word_t mem [MAP_WORDS];
  word_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/bba_checker.sv =====
// Port-level checks for the bitmap block allocator, bound to the top level.
module bba_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic        out_ok,
  input logic [47:0] out_alloc_address,
  input logic        out_bit_read
);

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("item taken without going busy");

  a_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("block still busy after result");

  a_fail_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_alloc_address == 48'd0 && !out_bit_read))
    else $error("failed item carries payload");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_ok            (out_ok),
  .out_alloc_address (out_alloc_address),
  .out_bit_read      (out_bit_read)
);
